### design/utf8_to_ucs2_decoder_top_macros.svh
// Assertion macros used by the decoder back end.
`ifndef UTF8_TO_UCS2_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTD_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### design/utd_pkg.sv
// Package with types and constants of the UTF-8 to UCS-2 decoder.
`default_nettype none
package utd_pkg;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [14:0] MAX_UNITS_RESET = 15'd149;

	typedef struct packed {
		logic        term;
		logic [15:0] unit;
	} evt_t;
endpackage
`default_nettype wire

### design/utd_front.sv
// Front end: accepts bytes, gathers multi-byte sequences and issues unit or terminator events.
`default_nettype none
module utd_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  in_byte,
	output utd_pkg::evt_t    ev,
	output logic             ev_push
);
	logic [1:0]  pending_q;
	logic [15:0] partial_q;
	logic [1:0]  pending_d;
	logic [15:0] partial_d;

	always_comb begin
		pending_d = pending_q;
		partial_d = partial_q;
		ev.term   = 1'b0;
		ev.unit   = 16'd0;
		ev_push   = 1'b0;
		if (pending_q != 2'd0) begin
			partial_d = {partial_q[9:0], in_byte[5:0]};
			pending_d = pending_q - 2'd1;
			ev.unit   = partial_d;
			ev_push   = accept && (pending_d == 2'd0);
		end else if (in_byte == 8'd0) begin
			ev.term   = 1'b1;
			ev_push   = accept;
			partial_d = 16'd0;
		end else if (!in_byte[7]) begin
			ev.unit   = {8'd0, in_byte};
			ev_push   = accept;
		end else if (!in_byte[5]) begin
			partial_d = {11'd0, in_byte[4:0]};
			pending_d = 2'd1;
		end else begin
			partial_d = {12'd0, in_byte[3:0]};
			pending_d = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= 16'd0;
		end else if (accept) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end
endmodule
`default_nettype wire

### design/utd_queue.sv
// Short event queue between the front end and the back end.
`default_nettype none
module utd_queue #(
	parameter int unsigned DEPTH = utd_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  utd_pkg::evt_t      din,
	output logic               full,
	input  wire logic          pop,
	output utd_pkg::evt_t      dout,
	output logic               avail
);
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	utd_pkg::evt_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign avail = (cnt_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

### design/utd_back.sv
// Back end: counts units against the capacity, drops overflow and drives the output word.
`default_nettype none
`include "utf8_to_ucs2_decoder_top_macros.svh"
module utd_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data,
	input  wire logic        ev_avail,
	input  utd_pkg::evt_t    ev,
	output logic             ev_pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_unit,
	output logic             is_last,
	output logic [15:0]      bytes_used
);
	logic [14:0] max_units_q;
	logic [14:0] units_q;
	logic        out_valid_q;
	logic [15:0] code_unit_q;
	logic        is_last_q;
	logic [15:0] bytes_used_q;
	logic        drop;

	assign cfg_ready  = 1'b1;
	assign ev_pop     = ev_avail && (!out_valid_q || !out_stall);
	assign drop       = !ev.term && (units_q >= max_units_q);
	assign out_valid  = out_valid_q;
	assign code_unit  = code_unit_q;
	assign is_last    = is_last_q;
	assign bytes_used = bytes_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= utd_pkg::MAX_UNITS_RESET;
			units_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_units_q <= cfg_data;
			end
			if (ev_pop && !drop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ev_pop) begin
				if (ev.term) begin
					units_q <= '0;
				end else if (!drop) begin
					units_q <= units_q + 15'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop && !drop) begin
			code_unit_q  <= ev.term ? 16'd0 : ev.unit;
			is_last_q    <= ev.term;
			bytes_used_q <= ev.term ? {units_q, 1'b0} : 16'd0;
		end
	end

	`UTD_ASSERT_NEXT(a_term_clears, clk, arst_n, ev_pop && ev.term, units_q == 15'd0, "unit count not cleared after terminator")
	`UTD_ASSERT_NEXT(a_drop_silent, clk, arst_n, ev_pop && drop, !out_valid_q, "dropped unit produced an output word")
	`UTD_ASSERT_IMPL(a_last_zero, clk, arst_n, out_valid_q && is_last_q, code_unit_q == 16'd0, "terminator word carries a nonzero unit")
	`UTD_ASSERT_IMPL(a_unit_nolen, clk, arst_n, out_valid_q && !is_last_q, bytes_used_q == 16'd0, "unit word carries a byte count")
endmodule
`default_nettype wire

### design/utf8_to_ucs2_decoder_top.sv
// Path: an accepted byte's event is written into the event queue, then registered as the output word.
// Throughput: one byte per cycle while in_stall is low; the event queue depth sets how long each side may stall alone.
// Bytes that only start or continue a sequence, and units beyond the capacity, yield no word.
// Reset: asynchronous, active low; clears sequence state, unit count and queue, capacity to 149.
// Top level: front end, event queue and back end of the lax UTF-8 to UCS-2 decoder.
`default_nettype none
module utf8_to_ucs2_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = utd_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_unit,
	output logic             is_last,
	output logic [15:0]      bytes_used
);
	utd_pkg::evt_t front_ev;
	utd_pkg::evt_t head_ev;
	logic          front_push;
	logic          q_full;
	logic          q_avail;
	logic          q_pop;

	assign in_stall = q_full;

	utd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_valid && !q_full),
		.in_byte (in_byte),
		.ev      (front_ev),
		.ev_push (front_push)
	);

	utd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.din    (front_ev),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (head_ev),
		.avail  (q_avail)
	);

	utd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.ev_avail   (q_avail),
		.ev         (head_ev),
		.ev_pop     (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_unit  (code_unit),
		.is_last    (is_last),
		.bytes_used (bytes_used)
	);
endmodule
`default_nettype wire

### verif/utf8_to_ucs2_decoder_top_test.sv
// Testbench for the lax UTF-8 to UCS-2 decoder: byte streams checked word by word.
module utf8_to_ucs2_decoder_top_test;
	typedef enum logic [1:0] {ITEM_BYTE, ITEM_CFG, ITEM_PAUSE} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [14:0] value;
	} stim_item_t;

	typedef struct packed {
		logic [15:0] code;
		logic        last;
		logic [15:0] used;
	} unit_word_t;

	localparam int unsigned CLK_PERIOD = 12;
	localparam int unsigned IDLE_PCT = 21;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned RANDOM_BYTES = 1500;
	localparam int unsigned PHASE_BYTES = 250;
	localparam int unsigned CALM_FIRST = 600;
	localparam int unsigned CALM_LAST = 900;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [14:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] code_unit;
	logic        is_last;
	logic [15:0] bytes_used;

	stim_item_t stim_q[$];
	unit_word_t unit_q[$];

	logic [1:0]  seq_pending;
	logic [15:0] seq_code;
	logic [14:0] unit_count;
	logic [14:0] unit_cap;

	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	int unsigned bytes_accepted;
	int unsigned bytes_queued;
	bit          byte_taken;
	bit          cfg_taken;

	utf8_to_ucs2_decoder_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_unit  (code_unit),
		.is_last    (is_last),
		.bytes_used (bytes_used)
	);

	initial clk = 1'b0;
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 15'd0;
		in_valid = 1'b0;
		in_byte = 8'd0;
		out_stall = 1'b0;
		seq_pending = 2'd0;
		seq_code = 16'd0;
		unit_count = 15'd0;
		unit_cap = utd_pkg::MAX_UNITS_RESET;
		mismatch_count = 0;
		quiet_cycles = 0;
		bytes_accepted = 0;
		byte_taken = 1'b0;
		cfg_taken = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
	end

	task automatic decode_byte(input logic [7:0] b);
		logic        emit;
		logic [15:0] val;
		unit_word_t  w;
		emit = 1'b0;
		val = 16'd0;
		if (seq_pending != 2'd0) begin
			seq_code = {seq_code[9:0], b[5:0]};
			seq_pending = seq_pending - 2'd1;
			emit = (seq_pending == 2'd0);
			val = seq_code;
		end else if (b == 8'd0) begin
			w.code = 16'd0;
			w.last = 1'b1;
			w.used = {unit_count, 1'b0};
			unit_q.push_back(w);
			seq_code = 16'd0;
			unit_count = 15'd0;
		end else if (!b[7]) begin
			emit = 1'b1;
			val = {8'd0, b};
		end else if (!b[5]) begin
			seq_code = {11'd0, b[4:0]};
			seq_pending = 2'd1;
		end else begin
			seq_code = {12'd0, b[3:0]};
			seq_pending = 2'd2;
		end
		if (emit && unit_count < unit_cap) begin
			unit_count = unit_count + 15'd1;
			w.code = val;
			w.last = 1'b0;
			w.used = 16'd0;
			unit_q.push_back(w);
		end
	endtask

	always @(posedge clk) begin : monitor
		unit_word_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (unit_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h %b %h",
						$time, code_unit, is_last, bytes_used);
					mismatch_count++;
				end else begin
					w = unit_q.pop_front();
					if (code_unit !== w.code) begin
						$display("%0t: code_unit expected %h, actual %h",
							$time, w.code, code_unit);
						mismatch_count++;
					end
					if (is_last !== w.last) begin
						$display("%0t: is_last expected %b, actual %b",
							$time, w.last, is_last);
						mismatch_count++;
					end
					if (bytes_used !== w.used) begin
						$display("%0t: bytes_used expected %h, actual %h",
							$time, w.used, bytes_used);
						mismatch_count++;
					end
				end
			end
			byte_taken = in_valid && !in_stall;
			cfg_taken = cfg_valid && cfg_ready;
			if (byte_taken) begin
				decode_byte(in_byte);
				quiet_cycles = 0;
				bytes_accepted++;
			end else if (quiet_cycles < 1000) begin
				quiet_cycles++;
			end
			if (cfg_taken) begin
				unit_cap = cfg_data;
			end
		end
	end

	always @(negedge clk) begin : driver
		logic next_valid;
		logic next_cfg;
		bit   calm;
		bit   settled;
		if (arst_n) begin
			next_valid = in_valid;
			next_cfg = cfg_valid;
			calm = bytes_accepted >= CALM_FIRST && bytes_accepted < CALM_LAST;
			if (byte_taken) next_valid = 1'b0;
			if (cfg_taken) next_cfg = 1'b0;
			settled = !next_valid && !next_cfg && unit_q.size() == 0 &&
				quiet_cycles >= SETTLE_CYCLES;
			if (!next_valid && !next_cfg && stim_q.size() != 0) begin
				case (stim_q[0].kind)
				ITEM_BYTE: begin
					if (calm || $urandom_range(99) >= IDLE_PCT) begin
						next_valid = 1'b1;
						in_byte <= stim_q[0].value[7:0];
						void'(stim_q.pop_front());
					end
				end
				ITEM_CFG: begin
					if (settled) begin
						next_cfg = 1'b1;
						cfg_data <= stim_q[0].value;
						void'(stim_q.pop_front());
					end
				end
				default: begin
					if (settled) void'(stim_q.pop_front());
				end
				endcase
			end
			in_valid <= next_valid;
			cfg_valid <= next_cfg;
			out_stall <= !calm && $urandom_range(99) < IDLE_PCT;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		stim_item_t it;
		it.kind = ITEM_BYTE;
		it.value = {7'd0, b};
		stim_q.push_back(it);
		bytes_queued++;
	endtask

	task automatic add_item(input item_kind_t kind, input logic [14:0] value);
		stim_item_t it;
		it.kind = kind;
		it.value = value;
		stim_q.push_back(it);
	endtask

	function automatic logic [7:0] tail_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5) return 8'd0;
		if (r < 15) return 8'($urandom_range(255));
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	task automatic add_random_unit();
		case ($urandom_range(2))
		0: add_byte(8'($urandom_range(127, 1)));
		1: begin
			add_byte($urandom_range(1) ? 8'($urandom_range(8'h9F, 8'h80)) :
				8'($urandom_range(8'hDF, 8'hC0)));
			add_byte(tail_byte());
		end
		default: begin
			add_byte($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'hA0)) :
				8'($urandom_range(8'hFF, 8'hE0)));
			add_byte(tail_byte());
			add_byte(tail_byte());
		end
		endcase
	endtask

	initial begin : stimulus
		logic [14:0] cap_plan[8];
		int unsigned n_units;
		int unsigned next_phase;
		int unsigned phase;
		bytes_queued = 0;
		cap_plan = '{15'd3, 15'd32767, 15'd1, 15'd0, 15'd20, 15'd7, 15'd0, 15'd149};

		add_byte(8'h00);
		add_byte(8'h41);
		add_byte(8'h7F);
		add_byte(8'h01);
		add_byte(8'hC3);
		add_byte(8'hA9);
		add_byte(8'h80);
		add_byte(8'hBF);
		add_byte(8'h9F);
		add_byte(8'hFF);
		add_byte(8'hE2);
		add_byte(8'h82);
		add_byte(8'hAC);
		add_byte(8'hFF);
		add_byte(8'hFF);
		add_byte(8'hFF);
		add_byte(8'hF0);
		add_byte(8'h9F);
		add_byte(8'h98);
		add_byte(8'hC2);
		add_byte(8'h00);
		add_byte(8'hE0);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(8'h00);

		for (int i = 0; i < 152; i++) add_byte(8'($urandom_range(127, 1)));
		add_byte(8'h00);

		add_item(ITEM_CFG, 15'd0);
		add_byte(8'h41);
		add_byte(8'hC3);
		add_byte(8'hA9);
		add_byte(8'h00);
		add_item(ITEM_CFG, 15'd32767);

		next_phase = bytes_queued + PHASE_BYTES;
		phase = 0;
		while (bytes_queued < RANDOM_BYTES) begin
			n_units = ($urandom_range(9) == 0) ? $urandom_range(60, 30) :
				$urandom_range(15);
			for (int u = 0; u < n_units; u++) begin
				add_random_unit();
				if ($urandom_range(99) < 4) add_byte(8'($urandom_range(255)));
				if ($urandom_range(99) < 2) add_item(ITEM_CFG, 15'($urandom_range(6)));
			end
			add_byte(8'h00);
			if ($urandom_range(99) < 5) add_item(ITEM_PAUSE, 15'd0);
			if (bytes_queued >= next_phase) begin
				add_item(ITEM_CFG,
					(phase == 5) ? 15'($urandom_range(30)) : cap_plan[phase % 8]);
				phase++;
				next_phase = bytes_queued + PHASE_BYTES;
			end
		end

		while (stim_q.size() != 0 || in_valid || cfg_valid) @(posedge clk);
		while (unit_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && unit_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * 200000);
		$display("*** FAILED ***");
		$finish;
	end
endmodule

### filelist.f
+incdir+design
design/utd_pkg.sv
design/utd_front.sv
design/utd_queue.sv
design/utd_back.sv
design/utf8_to_ucs2_decoder_top.sv
verif/utf8_to_ucs2_decoder_top_test.sv
